// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the Taylor sine/cosine unit
// Sequencer states, arithmetic unit sizes and the fixed numbers used to
// reduce an angle in degrees and turn it into radians.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_XDIV,
    ST_SQ,
    ST_TERM,
    ST_TMUL,
    ST_TDIV,
    ST_FIN
  } tsc_state_t;

  // Quotient bits retired by the divider in one cycle.
  localparam int DIGIT_BITS = 8;
  // Width of the multiplicand slice fed to the multiplier in one cycle.
  localparam int MUL_CHUNK  = 32;
  // Divisor width: wide enough for the radian denominator.
  localparam int DIVR_W     = 14;

  // Angle reduction and degree to radian conversion, pi taken as 3.14:
  // x = a * 157 / 9000, rounded half up.
  localparam logic [DIVR_W-1:0] FULL_TURN_DEG = 14'd360;
  localparam logic [DIVR_W-1:0] RAD_DEN       = 14'd9000;
  localparam int                RAD_NUM       = 157;
  localparam int                RAD_HALF      = 4500;

  // Clipping limits of the 32-bit result.
  localparam logic [31:0] SUM_POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] SUM_NEG_LIMIT = 32'h8000_0000;

endpackage

// File: rtl/tsc_mul.sv
// ----------------------------------------------------------------------------
// tsc_mul: shared multi-cycle multiplier
// Multiplies a by b one MUL_CHUNK-bit slice of a per cycle, most significant
// slice first, and returns the product shifted right by SHIFT bits.
// ----------------------------------------------------------------------------
module tsc_mul #(
  parameter int A_W   = 32,
  parameter int B_W   = 30,
  parameter int SHIFT = 24,
  parameter int OUT_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             done,
  output logic [OUT_W-1:0] res
);
  import tsc_pkg::*;

  localparam int CH    = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int A_PAD = CH * MUL_CHUNK;
  localparam int ACC_W = (A_PAD + B_W > SHIFT + OUT_W) ? A_PAD + B_W : SHIFT + OUT_W;
  localparam int CNT_W = $clog2(CH + 1);

  logic [A_PAD-1:0] a_r;
  logic [B_W-1:0]   b_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // The accumulator is shifted up one slice each cycle, so the result stays
  // exact modulo 2^ACC_W, which holds the whole product.
  always_comb begin
    acc_nxt = (acc_r << MUL_CHUNK)
            + ACC_W'(a_r[A_PAD-1 -: MUL_CHUNK]) * ACC_W'(b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= A_PAD'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_r << MUL_CHUNK;
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign res  = acc_r[SHIFT +: OUT_W];

endmodule

// File: rtl/tsc_div.sv
// ----------------------------------------------------------------------------
// tsc_div: shared multi-cycle divider
// Restoring long division of an unsigned dividend by a narrow divisor,
// DIGIT_BITS quotient bits per cycle. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module tsc_div #(
  parameter int DVD_W = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DVD_W-1:0]          dividend,
  input  logic [tsc_pkg::DIVR_W-1:0] divisor,
  output logic                      done,
  output logic [DVD_W-1:0]          quotient,
  output logic [tsc_pkg::DIVR_W-1:0] remainder
);
  import tsc_pkg::*;

  localparam int STEPS = (DVD_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_W = STEPS * DIGIT_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0]  dvd_r;
  logic [PAD_W-1:0]  dvd_nxt;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] rem_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  // Dividend bits leave at the top while quotient bits enter at the bottom,
  // so after the last step the register holds the quotient.
  always_comb begin
    logic [DIVR_W:0]  r;
    logic [PAD_W-1:0] d;
    r = {1'b0, rem_r};
    d = dvd_r;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      r = {r[DIVR_W-1:0], d[PAD_W-1]};
      d = {d[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_r}) begin
        r    = r - {1'b0, dvs_r};
        d[0] = 1'b1;
      end
    end
    rem_nxt = r[DIVR_W-1:0];
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r[DVD_W-1:0];
  assign remainder = rem_r;

endmodule

// File: rtl/taylor_sine_cosine_unit.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine_unit: fixed-point Taylor series sine and cosine
// Sequencer and datapath around one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries an angle in whole degrees, the index
// of the last series term and a mode bit (0 sine, 1 cosine). The angle is
// reduced modulo 360 keeping its sign and turned into radians with pi = 3.14.
// The result on the out_ channel is the partial sum in signed fixed point
// with FRAC_BITS fraction bits, clipped to 32 bits, and a clip flag.
// Every request, including the angle reduction, runs on the shared divider
// and the shared multiplier: two divisions give the reduced angle and x,
// one product gives x squared, and each further term takes one product and
// one division. in_tready is high only while no request is in work, so a
// new request is accepted only after the previous result has been loaded
// into the output register. A finished result sits in the output register;
// while the receiver stalls, the unit may accept and compute the next
// request and then holds it until the register frees. Reset empties the
// output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_unit #(
  parameter int MAX_TERMS = 15,
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] angle_degrees, [19:16] last_term_index, rest zero
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] series_sum
  output logic [0:0]  out_tuser   // [0] saturated
);
  import tsc_pkg::*;

  localparam int X_W   = FRAC_BITS + 3;
  localparam int X2_W  = FRAC_BITS + 6;
  localparam int MAG_W = FRAC_BITS + 8;
  localparam int DVD_W = FRAC_BITS + 16;
  localparam int SUM_W = (FRAC_BITS + 13 > 33) ? FRAC_BITS + 13 : 33;
  localparam int K_W   = $clog2(MAX_TERMS + 2);
  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

  tsc_state_t state_r, state_nxt;

  // Request fields.
  logic [15:0]      in_angle;
  logic [15:0]      in_abs;
  logic [K_W-1:0]   in_n_eff;

  // Per request registers.
  logic             angle_neg_r;
  logic             cos_r;
  logic [K_W-1:0]   n_r;
  logic [X_W-1:0]   x_r;
  logic [X2_W-1:0]  x2_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic [SUM_W-1:0] sum_r;
  logic [K_W-1:0]   k_r;
  logic [DIVR_W-1:0] d_r;
  logic [31:0]      out_sum_r;
  logic             out_sat_r;
  logic             out_tvalid_r;

  // Shared units.
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DIVR_W-1:0] div_dvs, div_rem;
  logic              mul_start, mul_done;
  logic [MAG_W-1:0]  mul_a;
  logic [X2_W-1:0]   mul_b;
  logic [DVD_W-1:0]  mul_res;

  // Sequencer controls.
  logic terms_done;
  logic ld_in, ld_x, ld_init, ld_term, ld_out;

  logic [SUM_W-1:0] term_ext;
  logic             sum_fits;

  assign in_angle = in_tdata[15:0];
  assign in_abs   = in_angle[15] ? (~in_angle + 16'd1) : in_angle;
  assign in_n_eff = (int'(in_tdata[19:16]) > MAX_TERMS) ? K_W'(MAX_TERMS)
                                                          : K_W'(in_tdata[19:16]);
  assign terms_done = (k_r > n_r);

  tsc_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  tsc_mul #(
    .A_W  (MAG_W),
    .B_W  (X2_W),
    .SHIFT(FRAC_BITS),
    .OUT_W(DVD_W)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  // Operand selection for the shared units.
  always_comb begin
    div_dvd = '0;
    div_dvs = FULL_TURN_DEG;
    mul_a   = mag_r;
    mul_b   = x2_r;
    case (state_r)
      ST_IDLE: begin
        div_dvd = DVD_W'(in_abs);
        div_dvs = FULL_TURN_DEG;
      end
      ST_MOD: begin
        // Reduced angle times 157, scaled, plus half the denominator.
        div_dvd = ((DVD_W'(RAD_NUM) * DVD_W'(div_rem)) << FRAC_BITS) + DVD_W'(RAD_HALF);
        div_dvs = RAD_DEN;
      end
      ST_XDIV: begin
        mul_a = MAG_W'(div_quo[X_W-1:0]);
        mul_b = X2_W'(div_quo[X_W-1:0]);
      end
      ST_TMUL: begin
        div_dvd = mul_res;
        div_dvs = d_r;
      end
      default: begin
        div_dvd = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MOD;
      ST_MOD:   if (div_done) state_nxt = ST_XDIV;
      ST_XDIV:  if (div_done) state_nxt = ST_SQ;
      ST_SQ:    if (mul_done) state_nxt = ST_TERM;
      ST_TERM:  state_nxt = terms_done ? ST_FIN : ST_TMUL;
      ST_TMUL:  if (mul_done) state_nxt = ST_TDIV;
      ST_TDIV:  if (div_done) state_nxt = ST_TERM;
      ST_FIN:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    ld_in     = 1'b0;
    ld_x      = 1'b0;
    ld_init   = 1'b0;
    ld_term   = 1'b0;
    ld_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid;
        ld_in     = in_tvalid;
      end
      ST_MOD:  div_start = div_done;
      ST_XDIV: begin
        mul_start = div_done;
        ld_x      = div_done;
      end
      ST_SQ:   ld_init = mul_done;
      ST_TERM: mul_start = !terms_done;
      ST_TMUL: div_start = mul_done;
      ST_TDIV: ld_term = div_done;
      ST_FIN:  ld_out = !out_tvalid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign term_ext = SUM_W'(div_quo[MAG_W-1:0]);
  // The sum fits in 32 bits when every bit from bit 31 up matches the sign.
  assign sum_fits = (&sum_r[SUM_W-1:31]) | ~(|sum_r[SUM_W-1:31]);

  always_ff @(posedge clk) begin
    if (ld_in) begin
      angle_neg_r <= in_angle[15];
      cos_r       <= in_tuser[0];
      n_r         <= in_n_eff;
    end
    if (ld_x) begin
      x_r <= div_quo[X_W-1:0];
    end
    if (ld_init) begin
      x2_r <= mul_res[X2_W-1:0];
      k_r  <= K_W'(1);
      if (cos_r) begin
        mag_r <= ONE_MAG;
        neg_r <= 1'b0;
        sum_r <= SUM_W'(ONE_MAG);
        d_r   <= DIVR_W'(2);
      end else begin
        mag_r <= MAG_W'(x_r);
        neg_r <= angle_neg_r;
        sum_r <= angle_neg_r ? -SUM_W'(x_r) : SUM_W'(x_r);
        d_r   <= DIVR_W'(6);
      end
    end
    if (ld_term) begin
      mag_r <= div_quo[MAG_W-1:0];
      neg_r <= ~neg_r;
      sum_r <= neg_r ? sum_r + term_ext : sum_r - term_ext;
      k_r   <= k_r + K_W'(1);
      // Next divisor: (2k+2)(2k+3) or (2k+1)(2k+2), stepped by 8k+6 or 8k+2.
      d_r   <= d_r + DIVR_W'({k_r, 3'b000}) + (cos_r ? DIVR_W'(2) : DIVR_W'(6));
    end
    if (ld_out) begin
      out_sat_r <= ~sum_fits;
      if (sum_fits) begin
        out_sum_r <= sum_r[31:0];
      end else if (sum_r[SUM_W-1]) begin
        out_sum_r <= SUM_NEG_LIMIT;
      end else begin
        out_sum_r <= SUM_POS_LIMIT;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_sat_r;

`ifndef ASSERT_OFF
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_start && mul_start))
    else $error("divider and multiplier started in the same cycle");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MOD || state_r == ST_XDIV || state_r == ST_TDIV))
    else $error("divider finished outside a divide state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_SQ || state_r == ST_TMUL))
    else $error("multiplier finished outside a multiply state");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TERM) |-> (k_r <= n_r + K_W'(1)))
    else $error("term counter ran past the last term");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_FIN))
    else $error("result loaded outside the final state");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata == SUM_POS_LIMIT || out_tdata == SUM_NEG_LIMIT))
    else $error("clip flag set on a value that is not a limit");
`endif

endmodule
